// ===== src/dpwl_pkg.sv =====
package dpwl_pkg;

  // Field widths
  localparam int IdBits  = 12;
  localparam int CntBits = 16;

  // Pool codes (other codes are invalid)
  localparam logic [1:0] POOL_COLD = 2'd0;
  localparam logic [1:0] POOL_HOT  = 2'd1;

  // Threshold after reset
  localparam logic [CntBits-1:0] THRESHOLD_RESET = CntBits'(16);

  typedef logic [IdBits-1:0]  id_t;
  typedef logic [CntBits-1:0] cnt_t;

  // One block record held in the input stage
  typedef struct packed {
    id_t        block_id;
    cnt_t       erase_count;
    cnt_t       recent_erase_count;
    logic [1:0] pool_code;
    logic       last_block;
  } rec_t;

  // True when a - b > t, without wrap
  function automatic logic gap_exceeds(input cnt_t a, input cnt_t b,
                                       input logic [CntBits:0] t);
    logic [CntBits+1:0] sum;
    sum = {2'b00, b} + {1'b0, t};
    return {2'b00, a} > sum;
  endfunction

endpackage

// ===== src/dual_pool_wear_level_monitor.sv =====
// Channel  Direction  Handshake             Word
// in       input      in_valid / in_ready   block_id, erase_count, recent_erase_count,
//                                           pool_code, last_block
// out      output     out_valid / out_ready scan_error, migration_due, block picks,
//                                           overall_max_erase, overall_min_erase
// cfg      input      cfg_valid / cfg_ready cfg_data (wear threshold)
//
// One record is accepted per cycle while in_ready is high; an input register and a
// result register bound the single compare pass, so a result is registered once its
// last record leaves the input register.
// Reset sets the threshold to 16 and empties all trackers.
// in_ready drops only while a last record sits in the input register and the
// result register still holds a word that is not taken.
module dual_pool_wear_level_monitor
  import dpwl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Record channel
  input  logic       in_valid,
  output logic       in_ready,
  input  id_t        block_id,
  input  cnt_t       erase_count,
  input  cnt_t       recent_erase_count,
  input  logic [1:0] pool_code,
  input  logic       last_block,
  // Result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scan_error,
  output logic       migration_due,
  output id_t        oldest_hot_block,
  output id_t        youngest_cold_block,
  output logic       hot_adjust_due,
  output id_t        hot_min_block,
  output logic       cold_adjust_due,
  output id_t        cold_max_recent_block,
  output cnt_t       overall_max_erase,
  output cnt_t       overall_min_erase,
  // Configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cnt_t       cfg_data
);

  cnt_t threshold;

  // Input register
  logic s1_valid;
  rec_t s1;

  // Trackers
  cnt_t hot_max_erase, hot_max_erase_next;
  id_t  hot_max_idx, hot_max_idx_next;
  cnt_t hot_min_erase, hot_min_erase_next;
  id_t  hot_min_idx, hot_min_idx_next;
  cnt_t hot_min_recent, hot_min_recent_next;
  cnt_t cold_max_recent, cold_max_recent_next;
  id_t  cold_max_idx, cold_max_idx_next;
  cnt_t cold_min_erase, cold_min_erase_next;
  id_t  cold_min_idx, cold_min_idx_next;
  cnt_t all_max_erase, all_max_erase_next;
  cnt_t all_min_erase, all_min_erase_next;
  logic hot_seen, hot_seen_next;
  logic cold_seen, cold_seen_next;
  logic any_seen;
  logic err_seen, err_seen_next;

  logic s1_fire;
  logic in_fire;

  // Result values from the updated trackers
  cnt_t hmax, hmin, hminr, cmaxr, cmin;
  id_t  hmax_i, hmin_i, cmaxr_i, cmin_i;
  logic [CntBits:0] thr_x1, thr_x2;

  assign cfg_ready = 1'b1;

  // Hold a last record while the result register is full and not draining
  assign s1_fire  = s1_valid && !(s1.last_block && out_valid && !out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= '{block_id: block_id, erase_count: erase_count,
              recent_erase_count: recent_erase_count,
              pool_code: pool_code, last_block: last_block};
    end
  end

  // Fold the held record into the trackers
  always_comb begin
    hot_max_erase_next   = hot_max_erase;
    hot_max_idx_next     = hot_max_idx;
    hot_min_erase_next   = hot_min_erase;
    hot_min_idx_next     = hot_min_idx;
    hot_min_recent_next  = hot_min_recent;
    cold_max_recent_next = cold_max_recent;
    cold_max_idx_next    = cold_max_idx;
    cold_min_erase_next  = cold_min_erase;
    cold_min_idx_next    = cold_min_idx;
    hot_seen_next        = hot_seen;
    cold_seen_next       = cold_seen;
    err_seen_next        = err_seen;

    all_max_erase_next = (!any_seen || s1.erase_count > all_max_erase) ?
                         s1.erase_count : all_max_erase;
    all_min_erase_next = (!any_seen || s1.erase_count < all_min_erase) ?
                         s1.erase_count : all_min_erase;

    if (s1.pool_code == POOL_HOT) begin
      // maxima keep the first block, minima move to the last equal one
      if (!hot_seen || s1.erase_count > hot_max_erase) begin
        hot_max_erase_next = s1.erase_count;
        hot_max_idx_next   = s1.block_id;
      end
      if (!hot_seen || s1.erase_count <= hot_min_erase) begin
        hot_min_erase_next = s1.erase_count;
        hot_min_idx_next   = s1.block_id;
      end
      if (!hot_seen || s1.recent_erase_count <= hot_min_recent) begin
        hot_min_recent_next = s1.recent_erase_count;
      end
      hot_seen_next = 1'b1;
    end else if (s1.pool_code == POOL_COLD) begin
      if (!cold_seen || s1.recent_erase_count > cold_max_recent) begin
        cold_max_recent_next = s1.recent_erase_count;
        cold_max_idx_next    = s1.block_id;
      end
      if (!cold_seen || s1.erase_count <= cold_min_erase) begin
        cold_min_erase_next = s1.erase_count;
        cold_min_idx_next   = s1.block_id;
      end
      cold_seen_next = 1'b1;
    end else begin
      err_seen_next = 1'b1;
    end
  end

  // Empty trackers report block 0 and count 0
  always_comb begin
    hmax    = hot_seen_next  ? hot_max_erase_next   : '0;
    hmax_i  = hot_seen_next  ? hot_max_idx_next     : '0;
    hmin    = hot_seen_next  ? hot_min_erase_next   : '0;
    hmin_i  = hot_seen_next  ? hot_min_idx_next     : '0;
    hminr   = hot_seen_next  ? hot_min_recent_next  : '0;
    cmaxr   = cold_seen_next ? cold_max_recent_next : '0;
    cmaxr_i = cold_seen_next ? cold_max_idx_next    : '0;
    cmin    = cold_seen_next ? cold_min_erase_next  : '0;
    cmin_i  = cold_seen_next ? cold_min_idx_next    : '0;
    thr_x1  = {1'b0, threshold};
    thr_x2  = {threshold, 1'b0};
  end

  // Tracker registers; clear after the last record of a scan
  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1.last_block)) begin
      hot_max_erase   <= '0;
      hot_max_idx     <= '0;
      hot_min_erase   <= '1;
      hot_min_idx     <= '0;
      hot_min_recent  <= '1;
      cold_max_recent <= '0;
      cold_max_idx    <= '0;
      cold_min_erase  <= '1;
      cold_min_idx    <= '0;
      all_max_erase   <= '0;
      all_min_erase   <= '1;
      hot_seen        <= 1'b0;
      cold_seen       <= 1'b0;
      any_seen        <= 1'b0;
      err_seen        <= 1'b0;
    end else if (s1_fire) begin
      hot_max_erase   <= hot_max_erase_next;
      hot_max_idx     <= hot_max_idx_next;
      hot_min_erase   <= hot_min_erase_next;
      hot_min_idx     <= hot_min_idx_next;
      hot_min_recent  <= hot_min_recent_next;
      cold_max_recent <= cold_max_recent_next;
      cold_max_idx    <= cold_max_idx_next;
      cold_min_erase  <= cold_min_erase_next;
      cold_min_idx    <= cold_min_idx_next;
      all_max_erase   <= all_max_erase_next;
      all_min_erase   <= all_min_erase_next;
      hot_seen        <= hot_seen_next;
      cold_seen       <= cold_seen_next;
      any_seen        <= 1'b1;
      err_seen        <= err_seen_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1.last_block) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register word
  always_ff @(posedge clk) begin
    if (s1_fire && s1.last_block) begin
      scan_error            <= err_seen_next;
      migration_due         <= !err_seen_next && gap_exceeds(hmax, cmin, thr_x1);
      hot_adjust_due        <= !err_seen_next && gap_exceeds(hmax, hmin, thr_x2);
      cold_adjust_due       <= !err_seen_next && gap_exceeds(cmaxr, hminr, thr_x1);
      oldest_hot_block      <= hmax_i;
      youngest_cold_block   <= cmin_i;
      hot_min_block         <= hmin_i;
      cold_max_recent_block <= cmaxr_i;
      overall_max_erase     <= all_max_erase_next;
      overall_min_erase     <= all_min_erase_next;
    end
  end

  // Checks
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1.last_block |=> !any_seen && !hot_seen && !cold_seen && !err_seen)
    else $error("trackers not cleared after last record");

  a_error_mutes: assert property (@(posedge clk) disable iff (rst)
    out_valid && scan_error |-> !migration_due && !hot_adjust_due && !cold_adjust_due)
    else $error("trigger raised in a scan with a pool code error");

  a_hot_order: assert property (@(posedge clk) disable iff (rst)
    hot_seen |-> hot_min_erase <= hot_max_erase)
    else $error("hot pool minimum above maximum");

  a_all_order: assert property (@(posedge clk) disable iff (rst)
    any_seen |-> all_min_erase <= all_max_erase)
    else $error("overall minimum above maximum");

  a_pool_implies_any: assert property (@(posedge clk) disable iff (rst)
    hot_seen || cold_seen || err_seen |-> any_seen)
    else $error("pool flag set with no record seen");

endmodule
